[sv/wpb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_pkg: shared types and constants for the waveform peak bucket unit
// Field widths, configuration register indexes and the divider handshake.
// ----------------------------------------------------------------------------
package wpb_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned MAX_RUN_DEF     = 64;

  localparam int unsigned TOTAL_W  = 32;  // total_samples width
  localparam int unsigned BUCKET_W = 16;  // bucket_count and bucket_number width
  localparam int unsigned CUR_W    = 17;  // open bucket index, can reach bucket_count
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT  = 1'b1;

  typedef struct packed {
    logic                start;
    logic [TOTAL_W-1:0]  dividend;
    logic [BUCKET_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [TOTAL_W-1:0]  quot;
    logic [BUCKET_W-1:0] rem;
  } div_rsp_t;

endpackage

[sv/wpb_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_div: iterative restoring divider
// Divides the clip length by the bucket count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wpb_pkg::div_req_t req,
  output wpb_pkg::div_rsp_t rsp
);
  import wpb_pkg::*;

  localparam int unsigned STEP_W = $clog2(TOTAL_W + 1);

  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [TOTAL_W-1:0]  quot_r, quot_nxt;
  logic [BUCKET_W-1:0] rem_r, rem_nxt;
  logic [BUCKET_W-1:0] dsr_r, dsr_nxt;
  logic [BUCKET_W:0]   trial;
  logic [BUCKET_W:0]   diff;
  logic                fits;

  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quot_r[TOTAL_W-1]};
    diff     = trial - {1'b0, dsr_r};
    fits     = (trial >= {1'b0, dsr_r});
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      // Shift in the next dividend bit and subtract when the divisor fits.
      rem_nxt  = fits ? diff[BUCKET_W-1:0] : trial[BUCKET_W-1:0];
      quot_nxt = {quot_r[TOTAL_W-2:0], fits};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(TOTAL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      quot_r <= '0;
      rem_r  <= '0;
      dsr_r  <= '0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
      dsr_r  <= dsr_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider reports done while still busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && dsr_r != '0) |-> (rem_r < dsr_r))
    else $error("divider remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
`endif

endmodule

[sv/wpb_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_seq: bucket sequencer
// Tracks the clip position, the running min/max and the bucket boundaries,
// and closes buckets one per pass through its test and hand-off states.
// ----------------------------------------------------------------------------
module wpb_seq #(
  parameter int unsigned SAMPLE_BITS = wpb_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_RUN     = wpb_pkg::MAX_RUN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             restart,
  input  logic [wpb_pkg::TOTAL_W-1:0]      total,
  input  logic [wpb_pkg::BUCKET_W-1:0]     eff,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample,
  output wpb_pkg::div_req_t                div_req,
  input  wpb_pkg::div_rsp_t                div_rsp,
  output logic                             res_valid,
  input  logic                             res_take,
  output logic signed [SAMPLE_BITS-1:0]    res_min,
  output logic signed [SAMPLE_BITS-1:0]    res_max,
  output logic [wpb_pkg::BUCKET_W-1:0]     res_number,
  output logic                             res_last
);
  import wpb_pkg::*;

  localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_TEST = 3'd3;
  localparam logic [2:0] S_LAST = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [TOTAL_W-1:0]            pos_r, pos_nxt;
  logic [CUR_W-1:0]              cb_r, cb_nxt;
  logic [TOTAL_W-1:0]            nb_r, nb_nxt;
  logic [BUCKET_W-1:0]           br_r, br_nxt;
  logic [TOTAL_W-1:0]            quot_r, quot_nxt;
  logic [BUCKET_W-1:0]           srem_r, srem_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic signed [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic [RUN_W-1:0]              n_r, n_nxt;
  logic                          full_r, full_nxt;
  logic signed [SAMPLE_BITS-1:0] hmin_r, hmin_nxt;
  logic signed [SAMPLE_BITS-1:0] hmax_r, hmax_nxt;
  logic [BUCKET_W-1:0]           hnum_r, hnum_nxt;

  logic [TOTAL_W:0]   end_pos;
  logic               hit;
  logic               more;
  logic [CUR_W-1:0]   cb_inc;
  logic [BUCKET_W:0]  rsum;
  logic               wrap;
  logic [TOTAL_W-1:0] nb_step;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cb_nxt    = cb_r;
    nb_nxt    = nb_r;
    br_nxt    = br_r;
    quot_nxt  = quot_r;
    srem_nxt  = srem_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    smp_nxt   = smp_r;
    n_nxt     = n_r;
    full_nxt  = full_r;
    hmin_nxt  = hmin_r;
    hmax_nxt  = hmax_r;
    hnum_nxt  = hnum_r;

    div_req.start    = 1'b0;
    div_req.dividend = total;
    div_req.divisor  = eff;

    end_pos = {1'b0, pos_r} + (TOTAL_W + 1)'(1);
    hit     = (cb_r < CUR_W'(eff)) && ({1'b0, nb_r} <= end_pos) && (n_r < RUN_W'(MAX_RUN));
    more    = !full_r && hit;
    cb_inc  = cb_r + CUR_W'(1);
    rsum    = {1'b0, br_r} + {1'b0, srem_r};
    wrap    = (rsum >= {1'b0, eff});
    nb_step = nb_r + quot_r + TOTAL_W'(wrap);

    if (restart) begin
      pos_nxt   = '0;
      cb_nxt    = '0;
      min_nxt   = SMP_MAX;
      max_nxt   = SMP_MIN;
      state_nxt = S_PREP;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && eff != '0 && cb_r < CUR_W'(eff)) begin
            smp_nxt = in_sample;
            if (in_sample < min_r) min_nxt = in_sample;
            if (in_sample > max_r) max_nxt = in_sample;
            n_nxt     = '0;
            full_nxt  = 1'b0;
            state_nxt = S_TEST;
          end
        end
        S_PREP: begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            quot_nxt  = (eff == '0) ? '0 : div_rsp.quot;
            srem_nxt  = (eff == '0) ? '0 : div_rsp.rem;
            nb_nxt    = (eff == '0) ? '0 : div_rsp.quot;
            br_nxt    = (eff == '0) ? '0 : div_rsp.rem;
            state_nxt = S_IDLE;
          end
        end
        S_TEST: begin
          if (hit) begin
            hmin_nxt = min_r;
            hmax_nxt = max_r;
            hnum_nxt = cb_r[BUCKET_W-1:0];
            full_nxt = ({1'b0, nb_r} == end_pos);
            min_nxt  = smp_r;
            max_nxt  = smp_r;
            cb_nxt   = cb_inc;
            n_nxt    = n_r + RUN_W'(1);
            if (cb_inc < CUR_W'(eff)) begin
              nb_nxt = nb_step;
              br_nxt = wrap ? BUCKET_W'(rsum - {1'b0, eff}) : rsum[BUCKET_W-1:0];
            end
            state_nxt = S_LAST;
          end else begin
            pos_nxt   = pos_r + TOTAL_W'(1);
            state_nxt = S_IDLE;
          end
        end
        S_LAST: begin
          if (res_take) begin
            if (more) begin
              state_nxt = S_TEST;
            end else begin
              pos_nxt   = pos_r + TOTAL_W'(1);
              min_nxt   = SMP_MAX;
              max_nxt   = SMP_MIN;
              state_nxt = S_IDLE;
            end
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      cb_r    <= '0;
      nb_r    <= '0;
      br_r    <= '0;
      quot_r  <= '0;
      srem_r  <= '0;
      min_r   <= SMP_MAX;
      max_r   <= SMP_MIN;
      n_r     <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cb_r    <= cb_nxt;
      nb_r    <= nb_nxt;
      br_r    <= br_nxt;
      quot_r  <= quot_nxt;
      srem_r  <= srem_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      n_r     <= n_nxt;
      full_r  <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r  <= smp_nxt;
    hmin_r <= hmin_nxt;
    hmax_r <= hmax_nxt;
    hnum_r <= hnum_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_LAST);
  assign res_min    = hmin_r;
  assign res_max    = hmax_r;
  assign res_number = hnum_r;
  assign res_last   = !more;

`ifndef SYNTH
  a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !restart) |-> (cb_r <= CUR_W'(eff)))
    else $error("open bucket index beyond the bucket count");

  a_single_sample_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST && n_r != '0) |-> (min_r == max_r))
    else $error("follow-on bucket must cover only the current sample");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_take && !res_last && !restart) |=> (state_r == S_TEST))
    else $error("run ended although the bucket was not marked last");

  a_run_capped: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RUN_W'(MAX_RUN))
    else $error("run length over the cap");
`endif

endmodule

[sv/waveform_peak_buckets_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_peak_buckets_unit: min/max peak decimation for a waveform overview
// Splits a clip into buckets and reports the smallest and largest sample of
// each bucket as the sample that closes it arrives.
// ----------------------------------------------------------------------------
// Samples enter one item at a time on the in_ channel; each bucket leaves as
// one item on the out_ channel with its min, max, index and a flag on the last
// bucket closed by the same sample. A sample that closes no bucket passes
// through the test step alone. The sequencer closes one bucket per two-step
// pass (test, then hand-off to the output register, which waits while that
// register holds an item not yet taken). Every configuration write restarts
// the clip and runs the divider (one set-up step, 32 quotient bits, one
// hand-back), during which no sample is taken. Writes belong in idle
// periods only.
// ----------------------------------------------------------------------------
module waveform_peak_buckets_unit #(
  parameter int unsigned SAMPLE_BITS = wpb_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_RUN     = wpb_pkg::MAX_RUN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [wpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wpb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Sample input.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  // Bucket results.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   out_bucket_min,
  output logic signed [SAMPLE_BITS-1:0]   out_bucket_max,
  output logic [wpb_pkg::BUCKET_W-1:0]    out_bucket_number,
  output logic                            out_run_last
);
  import wpb_pkg::*;

  // Clamp bound (MAX_RUN-1)*total_samples needs the extra run bits.
  localparam int unsigned LIM_W = TOTAL_W + $clog2(MAX_RUN);

  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [BUCKET_W-1:0] bcnt_r, bcnt_nxt;
  logic [LIM_W-1:0]    lim;
  logic [BUCKET_W-1:0] eff;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                          res_valid;
  logic                          res_take;
  logic signed [SAMPLE_BITS-1:0] res_min;
  logic signed [SAMPLE_BITS-1:0] res_max;
  logic [BUCKET_W-1:0]           res_number;
  logic                          res_last;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] omin_r, omin_nxt;
  logic signed [SAMPLE_BITS-1:0] omax_r, omax_nxt;
  logic [BUCKET_W-1:0]           onum_r, onum_nxt;
  logic                          olast_r, olast_nxt;

  // Configuration registers. Any write restarts the clip in the sequencer.
  always_comb begin
    total_nxt = total_r;
    bcnt_nxt  = bcnt_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL_SAMPLES: total_nxt = cfg_wdata[TOTAL_W-1:0];
        REG_BUCKET_COUNT:  bcnt_nxt  = cfg_wdata[BUCKET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      bcnt_r  <= '0;
    end else begin
      total_r <= total_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

  // Effective bucket count: zero for an empty clip, otherwise limited so that
  // one sample never closes more than MAX_RUN buckets. When the limit applies
  // it is at most the requested count, so it fits the bucket width.
  assign lim = LIM_W'(total_r) * LIM_W'(MAX_RUN - 1);

  always_comb begin
    if (total_r == '0) begin
      eff = '0;
    end else if (LIM_W'(bcnt_r) < lim) begin
      eff = bcnt_r;
    end else begin
      eff = lim[BUCKET_W-1:0];
    end
  end

  wpb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wpb_seq #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_RUN     (MAX_RUN)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .total      (total_r),
    .eff        (eff),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res_min    (res_min),
    .res_max    (res_max),
    .res_number (res_number),
    .res_last   (res_last)
  );

  // Output register: the sequencer hands a bucket over whenever the register
  // is empty or its item is being taken in the same cycle.
  assign res_take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    omin_nxt      = omin_r;
    omax_nxt      = omax_r;
    onum_nxt      = onum_r;
    olast_nxt     = olast_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      omin_nxt      = res_min;
      omax_nxt      = res_max;
      onum_nxt      = res_number;
      olast_nxt     = res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    omin_r  <= omin_nxt;
    omax_r  <= omax_nxt;
    onum_r  <= onum_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_bucket_min    = omin_r;
  assign out_bucket_max    = omax_r;
  assign out_bucket_number = onum_r;
  assign out_run_last      = olast_r;

endmodule

[test/tb_waveform_peak_buckets_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_peak_buckets_unit: self-checking bench for the peak bucket unit
// Drives clips of audio samples under several register settings and handshake
// patterns, and checks every bucket item against a predictor or a directed row.
// ----------------------------------------------------------------------------
module tb_waveform_peak_buckets_unit;
  import wpb_pkg::*;

  localparam int SW             = SAMPLE_BITS_DEF;
  localparam int RUN_CAP        = MAX_RUN_DEF;
  // The divider runs after each register write; the bench leaves a settle gap
  // longer than a divider pass before each write and at the end.
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 3000;
  // Samples inside a clip for the random part.
  localparam int RANDOM_ITEMS   = 120;

  localparam logic signed [SW-1:0] PEAK_POS = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] PEAK_NEG = {1'b1, {(SW-1){1'b0}}};

  // One bucket as it leaves the block.
  typedef struct {
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
    logic [BUCKET_W-1:0]  index;
    logic                 closing;
  } bucket_t;

  // Rows of the directed table. A free row is checked against the predictor;
  // a quiet row must produce nothing; a single row carries its one bucket.
  typedef enum logic [1:0] {ROW_CFG, ROW_FREE, ROW_QUIET, ROW_ONE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] sel;
    logic [31:0]          value;
    bucket_t              want;
  } row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [SW-1:0]        in_sample;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [SW-1:0]        out_bucket_min;
  logic signed [SW-1:0]        out_bucket_max;
  logic [BUCKET_W-1:0]         out_bucket_number;
  logic                        out_run_last;

  // Handshake pressure of the current phase, in percent.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Bookkeeping for the summary and the verdict.
  int fail_count      = 0;
  int buckets_checked = 0;
  int samples_sent    = 0;
  int live_samples    = 0;
  int cfg_writes      = 0;
  int widest_burst    = 0;
  int quiet_cycles    = 0;

  // Predictor state: register copies, derived step sizes and the open bucket.
  longint unsigned clip_len, bucket_req, live_buckets, step_q, step_r;
  longint unsigned position, open_idx, boundary, bound_acc;
  logic signed [SW-1:0] peak_lo, peak_hi;

  bucket_t fresh_q[$];   // buckets closed by the sample just accepted
  bucket_t bucket_q[$];  // buckets still owed by the block, oldest first
  row_t    plan[$];

  waveform_peak_buckets_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bucket_min   (out_bucket_min),
    .out_bucket_max   (out_bucket_max),
    .out_bucket_number(out_bucket_number),
    .out_run_last     (out_run_last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Any register write starts the clip over. The bucket count is clamped so
  // that one sample can never close more than 63 buckets, and an empty clip or
  // a zero bucket count leaves nothing to report.
  function automatic void restart_clip();
    longint unsigned cap;
    cap = clip_len * longint'(RUN_CAP - 1);
    live_buckets = (bucket_req < cap) ? bucket_req : cap;
    if (clip_len == 0) live_buckets = 0;
    if (live_buckets != 0) begin
      step_q = clip_len / live_buckets;
      step_r = clip_len % live_buckets;
    end else begin
      step_q = 0;
      step_r = 0;
    end
    boundary  = step_q;
    bound_acc = step_r;
    position  = 0;
    open_idx  = 0;
    peak_lo   = PEAK_POS;
    peak_hi   = PEAK_NEG;
  endfunction

  // Folds one sample into the open bucket and collects, in fresh_q, every
  // bucket that this sample closes. Returns 0 when the sample is ignored.
  function automatic bit close_buckets(input logic signed [SW-1:0] s);
    longint unsigned end_here;
    bit              stop;
    bucket_t         b;
    fresh_q.delete();
    if (live_buckets == 0 || open_idx >= live_buckets) return 1'b0;
    if (s < peak_lo) peak_lo = s;
    if (s > peak_hi) peak_hi = s;
    end_here = position + 1;
    stop = 1'b0;
    while (!stop && open_idx < live_buckets && boundary <= end_here &&
           fresh_q.size() < RUN_CAP) begin
      // A bucket ending exactly here is the last one this sample can close.
      stop      = (boundary == end_here);
      b.lo      = peak_lo;
      b.hi      = peak_hi;
      b.index   = BUCKET_W'(open_idx);
      b.closing = 1'b0;
      fresh_q.push_back(b);
      // Any further bucket closed by this sample holds this sample alone.
      peak_lo = s;
      peak_hi = s;
      open_idx++;
      if (open_idx < live_buckets) begin
        bound_acc += step_r;
        boundary  += step_q;
        if (bound_acc >= live_buckets) begin
          bound_acc -= live_buckets;
          boundary++;
        end
      end
    end
    if (fresh_q.size() != 0) begin
      b = fresh_q.pop_back();
      b.closing = 1'b1;
      fresh_q.push_back(b);
      peak_lo = PEAK_POS;
      peak_hi = PEAK_NEG;
    end
    position++;
    return 1'b1;
  endfunction

  function automatic void plan_row(input row_kind_t kind, input logic [CFG_IDX_W-1:0] sel,
                                   input logic [31:0] value, input logic signed [SW-1:0] lo,
                                   input logic signed [SW-1:0] hi,
                                   input logic [BUCKET_W-1:0] index);
    row_t r;
    r.kind         = kind;
    r.sel          = sel;
    r.value        = value;
    r.want.lo      = lo;
    r.want.hi      = hi;
    r.want.index   = index;
    r.want.closing = 1'b1;
    plan.push_back(r);
  endfunction

  // Registers are only written while the block is idle: the input is held
  // off, every owed bucket must have arrived, and the divider of any earlier
  // write must have finished before the next write goes in.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [31:0] value);
    in_valid <= 1'b0;
    while (bucket_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_TOTAL_SAMPLES) clip_len = value;
    else bucket_req = value[BUCKET_W-1:0];
    restart_clip();
    cfg_writes++;
  endtask

  // Offers one sample and returns right after the edge that accepted it, with
  // the buckets it closes in fresh_q. Valid is left high so that a following
  // item can go out back to back; an idle gap lowers it first.
  task automatic send_sample(input logic signed [SW-1:0] value, output bit live);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (!in_ready);
    live = close_buckets(value);
    samples_sent++;
    if (live) live_samples++;
    if (fresh_q.size() > widest_burst) widest_burst = fresh_q.size();
  endtask

  // The receiver stalls at random with the pressure of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every bucket that leaves the block is compared with the oldest one owed.
  always @(posedge clk) begin
    bucket_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bucket_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: bucket with nothing owed: number %0d min %0d max %0d last %0b",
                 $time, out_bucket_number, out_bucket_min, out_bucket_max, out_run_last);
      end else begin
        want = bucket_q.pop_front();
        buckets_checked++;
        if (out_bucket_min !== want.lo || out_bucket_max !== want.hi ||
            out_bucket_number !== want.index || out_run_last !== want.closing) begin
          fail_count++;
          $display("%0t ns: bucket mismatch: expected number %0d min %0d max %0d last %0b, %s",
                   $time, want.index, want.lo, want.hi, want.closing,
                   $sformatf("got number %0d min %0d max %0d last %0b", out_bucket_number,
                             out_bucket_min, out_bucket_max, out_run_last));
        end
      end
    end
  end

  // The watchdog ends a run in which no item and no write has moved for too
  // long; the longest legal pause is a settle gap plus a divider pass.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, nothing moved for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t                 row;
    bit                   live;
    int                   phase;
    int                   random_live;
    int                   n_items;
    int                   hold_at;
    int                   pick;
    logic [31:0]          tot;
    logic [31:0]          bkt;
    logic [31:0]          raw;
    logic signed [SW-1:0] smp;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_sample = '0;
    out_ready = 1'b0;
    clip_len   = 0;
    bucket_req = 0;
    restart_clip();

    // Directed table. Out of reset both registers are zero, so the first
    // sample must produce nothing; so must a zero bucket count.
    plan_row(ROW_QUIET, REG_TOTAL_SAMPLES, 32'h007F_FFFF, '0, '0, '0);
    plan_row(ROW_CFG,   REG_TOTAL_SAMPLES, 32'd4,         '0, '0, '0);
    plan_row(ROW_QUIET, REG_TOTAL_SAMPLES, 32'h0012_3456, '0, '0, '0);
    // Bits above the bucket count width must be dropped: this is four buckets.
    plan_row(ROW_CFG,   REG_BUCKET_COUNT,  32'hABCD_0004, '0, '0, '0);
    // One sample per bucket: each bucket is that sample alone.
    plan_row(ROW_ONE,   REG_TOTAL_SAMPLES, 32'h007F_FFFF, PEAK_POS, PEAK_POS, 16'd0);
    plan_row(ROW_ONE,   REG_TOTAL_SAMPLES, 32'h0080_0000, PEAK_NEG, PEAK_NEG, 16'd1);
    plan_row(ROW_ONE,   REG_TOTAL_SAMPLES, 32'h0000_0000, '0, '0, 16'd2);
    plan_row(ROW_ONE,   REG_TOTAL_SAMPLES, 32'h00FF_FFFF, {SW{1'b1}}, {SW{1'b1}}, 16'd3);
    // The clip is done, so a further sample is ignored.
    plan_row(ROW_QUIET, REG_TOTAL_SAMPLES, 32'h0000_0005, '0, '0, '0);
    // Far too many buckets for one sample: clamped to 63, all closed at once.
    plan_row(ROW_CFG,   REG_TOTAL_SAMPLES, 32'd1,         '0, '0, '0);
    plan_row(ROW_CFG,   REG_BUCKET_COUNT,  32'd65535,     '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h002A_AAAA, '0, '0, '0);
    plan_row(ROW_QUIET, REG_TOTAL_SAMPLES, 32'h0055_5555, '0, '0, '0);
    // An empty clip reports nothing whatever the bucket count.
    plan_row(ROW_CFG,   REG_TOTAL_SAMPLES, 32'd0,         '0, '0, '0);
    plan_row(ROW_QUIET, REG_TOTAL_SAMPLES, 32'h007F_FFFF, '0, '0, '0);
    // Two buckets of three samples; the first spans both extremes.
    plan_row(ROW_CFG,   REG_TOTAL_SAMPLES, 32'd6,         '0, '0, '0);
    plan_row(ROW_CFG,   REG_BUCKET_COUNT,  32'd2,         '0, '0, '0);
    plan_row(ROW_QUIET, REG_TOTAL_SAMPLES, 32'h0080_0000, '0, '0, '0);
    plan_row(ROW_QUIET, REG_TOTAL_SAMPLES, 32'h007F_FFFF, '0, '0, '0);
    plan_row(ROW_ONE,   REG_TOTAL_SAMPLES, 32'h0000_0005, PEAK_NEG, PEAK_POS, 16'd0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h0000_0001, '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h00FF_FFFE, '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h0000_0003, '0, '0, '0);
    // Uneven buckets need the remainder carry; a rewrite mid-clip restarts it.
    plan_row(ROW_CFG,   REG_TOTAL_SAMPLES, 32'd7,         '0, '0, '0);
    plan_row(ROW_CFG,   REG_BUCKET_COUNT,  32'd3,         '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h0010_0000, '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h00F0_0000, '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h000A_BCDE, '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h007F_FFF0, '0, '0, '0);
    plan_row(ROW_CFG,   REG_BUCKET_COUNT,  32'd3,         '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h0000_0042, '0, '0, '0);
    // Bucket count right at the clamp bound: 63 buckets per sample.
    plan_row(ROW_CFG,   REG_TOTAL_SAMPLES, 32'd3,         '0, '0, '0);
    plan_row(ROW_CFG,   REG_BUCKET_COUNT,  32'd189,       '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h0000_0003, '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h0080_0001, '0, '0, '0);
    plan_row(ROW_FREE,  REG_TOTAL_SAMPLES, 32'h007F_FFFE, '0, '0, '0);
    // The longest clip with one bucket: no sample here comes near its end.
    plan_row(ROW_CFG,   REG_TOTAL_SAMPLES, 32'hFFFF_FFFF, '0, '0, '0);
    plan_row(ROW_CFG,   REG_BUCKET_COUNT,  32'd1,         '0, '0, '0);
    plan_row(ROW_QUIET, REG_TOTAL_SAMPLES, 32'h0000_0001, '0, '0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed rows run with light pressure on both sides.
    send_idle_pct = 30;
    stall_pct     = 30;
    foreach (plan[i]) begin
      row = plan[i];
      case (row.kind)
        ROW_CFG: begin
          write_reg(row.sel, row.value);
        end
        ROW_FREE: begin
          send_sample(row.value[SW-1:0], live);
          foreach (fresh_q[k]) bucket_q.push_back(fresh_q[k]);
        end
        ROW_QUIET: begin
          send_sample(row.value[SW-1:0], live);
        end
        default: begin
          send_sample(row.value[SW-1:0], live);
          bucket_q.push_back(row.want);
        end
      endcase
    end

    // Random phases. Each picks a clip shape, writes both registers in random
    // order and plays the clip, mostly to its end and a little past it. The
    // handshake pattern rotates: none, idle sender, stalling receiver, both.
    phase       = 0;
    random_live = 0;
    while (random_live < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase

      pick = $urandom_range(99);
      if (pick < 50) begin
        // Ordinary decimation: one or more samples per bucket.
        tot = $urandom_range(40, 4);
        bkt = $urandom_range(tot, 1);
      end else if (pick < 72) begin
        // At least as many buckets as samples: bursts from single samples.
        tot = $urandom_range(4, 1);
        bkt = $urandom_range(63 * tot, tot);
      end else if (pick < 82) begin
        // Above the clamp bound.
        tot = $urandom_range(3, 1);
        bkt = $urandom_range(65535, 63 * tot + 1);
      end else if (pick < 90) begin
        // Nothing to report: empty clip or zero buckets.
        if ($urandom_range(1)) begin
          tot = 0;
          bkt = $urandom_range(65535);
        end else begin
          tot = $urandom_range(40, 1);
          bkt = 0;
        end
      end else begin
        // Long clips: only the first few samples are played.
        tot = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom();
        bkt = $urandom_range(65535, 1);
      end

      if ($urandom_range(1)) begin
        write_reg(REG_TOTAL_SAMPLES, tot);
        write_reg(REG_BUCKET_COUNT, bkt);
      end else begin
        write_reg(REG_BUCKET_COUNT, bkt);
        write_reg(REG_TOTAL_SAMPLES, tot);
      end

      if (tot == 0 || tot > 64) n_items = $urandom_range(6, 2);
      else n_items = tot + $urandom_range(3);
      // Now and then the clip is cut short by the next phase's rewrite.
      if (pick < 50 && $urandom_range(7) == 0) n_items = $urandom_range(tot - 1, 1);

      // In the first phase and in some others the sender holds off at one
      // point until the block has delivered every bucket owed so far.
      hold_at = (phase == 0 || $urandom_range(3) == 0) ? $urandom_range(n_items - 1) : -1;

      for (int k = 0; k < n_items; k++) begin
        if (k == hold_at) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (bucket_q.size() != 0);
        end
        raw = $urandom();
        pick = $urandom_range(9);
        if (pick == 0) smp = PEAK_POS;
        else if (pick == 1) smp = PEAK_NEG;
        else smp = raw[SW-1:0];
        send_sample(smp, live);
        foreach (fresh_q[j]) bucket_q.push_back(fresh_q[j]);
        if (live) random_live++;
      end
      phase++;
    end

    // Drain: wait for every owed bucket, then give the block time to show
    // any bucket it should not produce.
    in_valid <= 1'b0;
    while (bucket_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d samples (%0d inside a clip) and %0d register writes.",
             samples_sent, live_samples, cfg_writes);
    $display("%0d buckets checked over %0d random clip setups; widest burst %0d buckets.",
             buckets_checked, phase, widest_burst);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
sv/wpb_pkg.sv
sv/wpb_div.sv
sv/wpb_seq.sv
sv/waveform_peak_buckets_unit.sv
test/tb_waveform_peak_buckets_unit.sv
